// ----- src/dynamic_loss_scale_controller_assert.svh -----
// Assertion macros shared by the loss-scale controller modules.
`ifndef DYNAMIC_LOSS_SCALE_CONTROLLER_ASSERT_SVH
`define DYNAMIC_LOSS_SCALE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DLSC_ASSERT_IMPLY(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("dlsc assertion failed");

// Next-cycle implication, disabled during reset.
`define DLSC_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("dlsc assertion failed");

`endif

// ----- src/dlsc_pkg.sv -----
// Shared types and constants of the dynamic loss-scale controller.
`default_nettype none

package dlsc_pkg;

  // Parameter defaults
  localparam int SCALE_WIDTH_DEF   = 48;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int COUNTER_WIDTH_DEF = 16;

  // Fixed register field widths
  localparam int CFG_SCALE_BITS = 48;
  localparam int FACTOR_W       = 24;
  localparam int BACKOFF_W      = 16;
  localparam int INTERVAL_W     = 16;
  localparam int CFG_INDEX_W    = 3;

  // Register reset values
  localparam logic [63:0] INIT_SCALE_RESET = 64'h0000_0001_0000_0000;
  localparam logic [63:0] MIN_SCALE_RESET  = 64'h0000_0000_0001_0000;
  localparam logic [63:0] MAX_SCALE_RESET  = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [BACKOFF_W-1:0]  BACKOFF_RESET  = 16'h8000;
  localparam logic [FACTOR_W-1:0]   GROWTH_RESET   = 24'h02_0000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd2000;

  // Single-precision exponent of infinity and NaN
  localparam logic [7:0] FLOAT_EXP_MAX = 8'hFF;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DYNAMIC_ENABLE  = 3'd0,
    REG_INITIAL_SCALE   = 3'd1,
    REG_MIN_SCALE       = 3'd2,
    REG_MAX_SCALE       = 3'd3,
    REG_BACKOFF_FACTOR  = 3'd4,
    REG_GROWTH_FACTOR   = 3'd5,
    REG_GROWTH_INTERVAL = 3'd6
  } cfg_reg_t;

  // Step health; HEALTH_OK doubles as "no non-finite word seen"
  typedef enum logic [1:0] {
    HEALTH_OK   = 2'd0,
    HEALTH_NAN  = 2'd1,
    HEALTH_INF  = 2'd2,
    HEALTH_ZERO = 2'd3
  } health_t;

  // Scale update chosen at the end of a step
  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_BACKOFF = 2'd1,
    OP_GROW    = 2'd2
  } scale_op_t;

  // Control passed from the front stage to the update stage
  typedef struct packed {
    health_t   health;
    scale_op_t op;
  } step_ctl_t;

endpackage

`default_nettype wire

// ----- src/dlsc_cfg_regs.sv -----
// Configuration register file of the loss-scale controller.
`default_nettype none

module dlsc_cfg_regs #(
  parameter int SCALE_WIDTH = dlsc_pkg::SCALE_WIDTH_DEF,
  localparam int CFG_DATA_W = (SCALE_WIDTH < dlsc_pkg::CFG_SCALE_BITS) ?
                              SCALE_WIDTH : dlsc_pkg::CFG_SCALE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [dlsc_pkg::CFG_INDEX_W-1:0]     cfg_addr,
  input  logic [CFG_DATA_W-1:0]                cfg_wdata,
  output logic                                 dynamic_enable,
  output logic [SCALE_WIDTH-1:0]               scale_floor,
  output logic [SCALE_WIDTH-1:0]               scale_ceiling,
  output logic [dlsc_pkg::BACKOFF_W-1:0]       backoff_mult,
  output logic [dlsc_pkg::FACTOR_W-1:0]        growth_mult,
  output logic [dlsc_pkg::INTERVAL_W-1:0]      grow_period,
  output logic                                 scale_load,
  output logic [SCALE_WIDTH-1:0]               scale_load_value
);

  logic [SCALE_WIDTH-1:0] wdata_scale;

  // Widen write data to scale width
  assign wdata_scale = SCALE_WIDTH'(cfg_wdata);

  // Writing the initial scale reloads the live scale, unless the update stage takes a request in the same cycle
  assign scale_load       = cfg_wr_en && (cfg_addr == dlsc_pkg::REG_INITIAL_SCALE);
  assign scale_load_value = wdata_scale;

  // Decode writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dynamic_enable <= 1'b0;
      scale_floor    <= SCALE_WIDTH'(dlsc_pkg::MIN_SCALE_RESET);
      scale_ceiling  <= SCALE_WIDTH'(dlsc_pkg::MAX_SCALE_RESET);
      backoff_mult   <= dlsc_pkg::BACKOFF_RESET;
      growth_mult    <= dlsc_pkg::GROWTH_RESET;
      grow_period    <= dlsc_pkg::INTERVAL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        dlsc_pkg::REG_DYNAMIC_ENABLE:  dynamic_enable <= cfg_wdata[0];
        dlsc_pkg::REG_MIN_SCALE:       scale_floor    <= wdata_scale;
        dlsc_pkg::REG_MAX_SCALE:       scale_ceiling  <= wdata_scale;
        dlsc_pkg::REG_BACKOFF_FACTOR:  backoff_mult   <= cfg_wdata[dlsc_pkg::BACKOFF_W-1:0];
        dlsc_pkg::REG_GROWTH_FACTOR:   growth_mult    <= cfg_wdata[dlsc_pkg::FACTOR_W-1:0];
        dlsc_pkg::REG_GROWTH_INTERVAL: grow_period    <= cfg_wdata[dlsc_pkg::INTERVAL_W-1:0];
        default: begin
          // initial scale is handled by the load strobe; unknown indexes drop
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/dlsc_front.sv -----
// Input stage: word classification, step verdict, counter and partial products.
`default_nettype none
`include "dynamic_loss_scale_controller_assert.svh"

module dlsc_front #(
  parameter int SCALE_WIDTH   = dlsc_pkg::SCALE_WIDTH_DEF,
  parameter int COUNTER_WIDTH = dlsc_pkg::COUNTER_WIDTH_DEF,
  localparam int LO_W = (SCALE_WIDTH + 1) / 2,
  localparam int HI_W = SCALE_WIDTH - LO_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              grad_valid,
  output logic                              grad_ready,
  input  logic [31:0]                       grad_bits,
  input  logic                              last_element,
  input  logic                              dynamic_enable,
  input  logic [dlsc_pkg::BACKOFF_W-1:0]    backoff_mult,
  input  logic [dlsc_pkg::FACTOR_W-1:0]     growth_mult,
  input  logic [dlsc_pkg::INTERVAL_W-1:0]   grow_period,
  input  logic [SCALE_WIDTH-1:0]            loss_scale,
  input  logic                              b_take,
  output logic                              b_valid,
  output dlsc_pkg::step_ctl_t               b_ctl,
  output logic [LO_W+dlsc_pkg::FACTOR_W-1:0] b_pp_lo,
  output logic [HI_W+dlsc_pkg::FACTOR_W-1:0] b_pp_hi
);

  localparam int CMP_W = (COUNTER_WIDTH > dlsc_pkg::INTERVAL_W) ?
                         COUNTER_WIDTH : dlsc_pkg::INTERVAL_W;

  logic                       a_valid;
  logic [31:0]                a_bits;
  logic                       a_last;
  logic                       a_go;
  dlsc_pkg::health_t          verdict;
  dlsc_pkg::health_t          verdict_word;
  dlsc_pkg::health_t          health;
  logic                       seen_nonzero;
  logic                       seen_word;
  logic                       is_special;
  logic [COUNTER_WIDTH-1:0]   clean_step_count;
  logic [COUNTER_WIDTH-1:0]   clean_step_count_next;
  logic [COUNTER_WIDTH-1:0]   count_inc;
  logic                       grow_hit;
  dlsc_pkg::scale_op_t        op;
  logic [dlsc_pkg::FACTOR_W-1:0] factor;
  logic [LO_W+dlsc_pkg::FACTOR_W-1:0] pp_lo_next;
  logic [HI_W+dlsc_pkg::FACTOR_W-1:0] pp_hi_next;

  // Advance a word; a last word waits until the update stage is empty
  assign a_go       = a_valid && (!a_last || !b_valid);
  assign grad_ready = !a_valid || a_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (grad_ready) begin
      a_valid <= grad_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (grad_ready && grad_valid) begin
      a_bits <= grad_bits;
      a_last <= last_element;
    end
  end

  // Classify the word and fold it into the step verdict
  assign is_special = (a_bits[30:23] == dlsc_pkg::FLOAT_EXP_MAX);
  assign seen_word  = seen_nonzero || (a_bits[30:0] != 31'd0);

  always_comb begin
    verdict_word = verdict;
    if (verdict == dlsc_pkg::HEALTH_OK && is_special) begin
      verdict_word = (a_bits[22:0] != 23'd0) ? dlsc_pkg::HEALTH_NAN : dlsc_pkg::HEALTH_INF;
    end
    if (verdict_word != dlsc_pkg::HEALTH_OK) begin
      health = verdict_word;
    end else if (!seen_word) begin
      health = dlsc_pkg::HEALTH_ZERO;
    end else begin
      health = dlsc_pkg::HEALTH_OK;
    end
  end

  // Choose the scale update and next counter value
  assign count_inc = clean_step_count + COUNTER_WIDTH'(1);
  assign grow_hit  = CMP_W'(count_inc) >= CMP_W'(grow_period);

  always_comb begin
    op                    = dlsc_pkg::OP_HOLD;
    clean_step_count_next = clean_step_count;
    if (dynamic_enable) begin
      if (health == dlsc_pkg::HEALTH_NAN || health == dlsc_pkg::HEALTH_INF) begin
        op                    = dlsc_pkg::OP_BACKOFF;
        clean_step_count_next = '0;
      end else if (grow_hit) begin
        op                    = dlsc_pkg::OP_GROW;
        clean_step_count_next = '0;
      end else begin
        clean_step_count_next = count_inc;
      end
    end
  end

  // Split the scale in halves and multiply each by the factor
  assign factor = (op == dlsc_pkg::OP_GROW) ? growth_mult :
                  dlsc_pkg::FACTOR_W'(backoff_mult);
  assign pp_lo_next = {{dlsc_pkg::FACTOR_W{1'b0}}, loss_scale[LO_W-1:0]} *
                      {{LO_W{1'b0}}, factor};
  assign pp_hi_next = {{dlsc_pkg::FACTOR_W{1'b0}}, loss_scale[SCALE_WIDTH-1:LO_W]} *
                      {{HI_W{1'b0}}, factor};

  // Step state: verdict, nonzero flag, clean-step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict          <= dlsc_pkg::HEALTH_OK;
      seen_nonzero     <= 1'b0;
      clean_step_count <= '0;
    end else if (a_go) begin
      if (a_last) begin
        verdict          <= dlsc_pkg::HEALTH_OK;
        seen_nonzero     <= 1'b0;
        clean_step_count <= clean_step_count_next;
      end else begin
        verdict      <= verdict_word;
        seen_nonzero <= seen_word;
      end
    end
  end

  // Update-stage request
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_go && a_last) begin
      b_valid <= 1'b1;
    end else if (b_take) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_last) begin
      b_ctl.health <= health;
      b_ctl.op     <= op;
      b_pp_lo      <= pp_lo_next;
      b_pp_hi      <= pp_hi_next;
    end
  end

  // Assertions
  `DLSC_ASSERT_NEXT(a_last_clears_step, clk, rst, a_go && a_last,
                    verdict == dlsc_pkg::HEALTH_OK && !seen_nonzero)
  `DLSC_ASSERT_NEXT(b_holds_when_stalled, clk, rst, b_valid && !b_take,
                    b_valid && $stable(b_pp_lo) && $stable(b_pp_hi) && $stable(b_ctl))

endmodule

`default_nettype wire

// ----- src/dlsc_update.sv -----
// Update stage: product sum, saturation, clamping, live scale and result register.
`default_nettype none
`include "dynamic_loss_scale_controller_assert.svh"

module dlsc_update #(
  parameter int SCALE_WIDTH   = dlsc_pkg::SCALE_WIDTH_DEF,
  parameter int FRACTION_BITS = dlsc_pkg::FRACTION_BITS_DEF,
  localparam int LO_W = (SCALE_WIDTH + 1) / 2,
  localparam int HI_W = SCALE_WIDTH - LO_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              b_valid,
  input  dlsc_pkg::step_ctl_t               b_ctl,
  input  logic [LO_W+dlsc_pkg::FACTOR_W-1:0] b_pp_lo,
  input  logic [HI_W+dlsc_pkg::FACTOR_W-1:0] b_pp_hi,
  output logic                              b_take,
  input  logic [SCALE_WIDTH-1:0]            scale_floor,
  input  logic [SCALE_WIDTH-1:0]            scale_ceiling,
  input  logic                              scale_load,
  input  logic [SCALE_WIDTH-1:0]            scale_load_value,
  output logic [SCALE_WIDTH-1:0]            loss_scale,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [1:0]                        health_code,
  output logic [SCALE_WIDTH-1:0]            scale_now,
  output logic                              scale_decreased,
  output logic                              scale_increased
);

  localparam int PROD_W = SCALE_WIDTH + dlsc_pkg::FACTOR_W;

  logic [PROD_W-1:0]      full;
  logic [PROD_W-1:0]      shifted;
  logic                   overflow;
  logic [SCALE_WIDTH-1:0] product;
  logic [SCALE_WIDTH-1:0] loss_scale_next;

  // Take a request when the result register is free or draining
  assign b_take = b_valid && (!result_valid || result_ready);

  // Recombine partial products, drop fraction bits, saturate
  assign full     = PROD_W'(b_pp_lo) + (PROD_W'(b_pp_hi) << LO_W);
  assign shifted  = full >> FRACTION_BITS;
  assign overflow = (full >> (FRACTION_BITS + SCALE_WIDTH)) != '0;
  assign product  = overflow ? '1 : shifted[SCALE_WIDTH-1:0];

  // Clamp by direction
  always_comb begin
    case (b_ctl.op)
      dlsc_pkg::OP_BACKOFF: loss_scale_next = (product < scale_floor) ? scale_floor : product;
      dlsc_pkg::OP_GROW:    loss_scale_next = (product > scale_ceiling) ? scale_ceiling : product;
      default:              loss_scale_next = loss_scale;
    endcase
  end

  // Live scale
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_scale <= SCALE_WIDTH'(dlsc_pkg::INIT_SCALE_RESET);
    end else if (b_take) begin
      loss_scale <= loss_scale_next;
    end else if (scale_load) begin
      loss_scale <= scale_load_value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      health_code     <= b_ctl.health;
      scale_now       <= loss_scale_next;
      scale_decreased <= (b_ctl.op == dlsc_pkg::OP_BACKOFF);
      scale_increased <= (b_ctl.op == dlsc_pkg::OP_GROW);
    end
  end

  // Assertions
  `DLSC_ASSERT_NEXT(hold_keeps_scale, clk, rst, b_take && b_ctl.op == dlsc_pkg::OP_HOLD,
                    scale_now == $past(loss_scale))
  `DLSC_ASSERT_IMPLY(backoff_only_nonfinite, clk, rst, result_valid && scale_decreased,
                     health_code == dlsc_pkg::HEALTH_NAN || health_code == dlsc_pkg::HEALTH_INF)
  `DLSC_ASSERT_IMPLY(one_direction, clk, rst, result_valid, !(scale_decreased && scale_increased))

endmodule

`default_nettype wire

// ----- src/dynamic_loss_scale_controller.sv -----
// Top level of the dynamic loss-scale controller.
//
//   channel   signals                                   transfer
//   -------   ---------------------------------------   -------------------------
//   grad      grad_bits, last_element                   grad_valid & grad_ready
//   result    health_code, scale_now, scale_decreased,  result_valid & result_ready
//             scale_increased
//   cfg       cfg_addr, cfg_wdata                       cfg_wr_en
//
// Words that are not last are taken one per cycle unless a last word waits in the
// input register; they only update the step verdict. A last word goes input register ->
// partial-product register -> result register. It waits in the input register while
// the previous last word still sits in the partial-product register, since the split
// multiply needs the updated scale.
// Reset is synchronous; control clears and the configuration registers load their defaults.
// With result_ready low the result holds, then the update stage, then the input register.
`default_nettype none

module dynamic_loss_scale_controller #(
  parameter int SCALE_WIDTH   = dlsc_pkg::SCALE_WIDTH_DEF,
  parameter int FRACTION_BITS = dlsc_pkg::FRACTION_BITS_DEF,
  parameter int COUNTER_WIDTH = dlsc_pkg::COUNTER_WIDTH_DEF,
  localparam int CFG_DATA_W = (SCALE_WIDTH < dlsc_pkg::CFG_SCALE_BITS) ?
                              SCALE_WIDTH : dlsc_pkg::CFG_SCALE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [dlsc_pkg::CFG_INDEX_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0]            cfg_wdata,
  input  logic                             grad_valid,
  output logic                             grad_ready,
  input  logic [31:0]                      grad_bits,
  input  logic                             last_element,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [1:0]                       health_code,
  output logic [SCALE_WIDTH-1:0]           scale_now,
  output logic                             scale_decreased,
  output logic                             scale_increased
);

  localparam int LO_W = (SCALE_WIDTH + 1) / 2;
  localparam int HI_W = SCALE_WIDTH - LO_W;

  logic                               dynamic_enable;
  logic [SCALE_WIDTH-1:0]             scale_floor;
  logic [SCALE_WIDTH-1:0]             scale_ceiling;
  logic [dlsc_pkg::BACKOFF_W-1:0]     backoff_mult;
  logic [dlsc_pkg::FACTOR_W-1:0]      growth_mult;
  logic [dlsc_pkg::INTERVAL_W-1:0]    grow_period;
  logic                               scale_load;
  logic [SCALE_WIDTH-1:0]             scale_load_value;
  logic [SCALE_WIDTH-1:0]             loss_scale;
  logic                               b_valid;
  logic                               b_take;
  dlsc_pkg::step_ctl_t                b_ctl;
  logic [LO_W+dlsc_pkg::FACTOR_W-1:0] b_pp_lo;
  logic [HI_W+dlsc_pkg::FACTOR_W-1:0] b_pp_hi;

  // Configuration registers
  dlsc_cfg_regs #(
    .SCALE_WIDTH (SCALE_WIDTH)
  ) u_cfg (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .dynamic_enable   (dynamic_enable),
    .scale_floor      (scale_floor),
    .scale_ceiling    (scale_ceiling),
    .backoff_mult     (backoff_mult),
    .growth_mult      (growth_mult),
    .grow_period      (grow_period),
    .scale_load       (scale_load),
    .scale_load_value (scale_load_value)
  );

  // Classification, verdict and multiply
  dlsc_front #(
    .SCALE_WIDTH   (SCALE_WIDTH),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .grad_valid      (grad_valid),
    .grad_ready      (grad_ready),
    .grad_bits       (grad_bits),
    .last_element    (last_element),
    .dynamic_enable  (dynamic_enable),
    .backoff_mult    (backoff_mult),
    .growth_mult     (growth_mult),
    .grow_period     (grow_period),
    .loss_scale      (loss_scale),
    .b_take          (b_take),
    .b_valid         (b_valid),
    .b_ctl           (b_ctl),
    .b_pp_lo         (b_pp_lo),
    .b_pp_hi         (b_pp_hi)
  );

  // Scale update and result
  dlsc_update #(
    .SCALE_WIDTH   (SCALE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_update (
    .clk              (clk),
    .rst              (rst),
    .b_valid          (b_valid),
    .b_ctl            (b_ctl),
    .b_pp_lo          (b_pp_lo),
    .b_pp_hi          (b_pp_hi),
    .b_take           (b_take),
    .scale_floor      (scale_floor),
    .scale_ceiling    (scale_ceiling),
    .scale_load       (scale_load),
    .scale_load_value (scale_load_value),
    .loss_scale       (loss_scale),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .health_code      (health_code),
    .scale_now        (scale_now),
    .scale_decreased  (scale_decreased),
    .scale_increased  (scale_increased)
  );

endmodule

`default_nettype wire

// ----- sim/dynamic_loss_scale_controller_tb.sv -----
// Self-checking testbench for the dynamic loss-scale controller: classification and scale updates.
`timescale 1ns / 100ps

module dynamic_loss_scale_controller_tb;

  localparam logic [dlsc_pkg::CFG_INDEX_W-1:0] UNMAPPED_REG_INDEX = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int WORDS_PER_PHASE = 130;
  localparam int RANDOM_PHASES = 10;

  // Register set applied between phases
  typedef struct {
    logic        dyn_enable;
    logic [47:0] init_scale;
    logic [47:0] min_limit;
    logic [47:0] max_limit;
    logic [15:0] backoff;
    logic [23:0] growth;
    logic [15:0] interval;
  } scale_settings_t;

  // One end-of-step report
  typedef struct packed {
    dlsc_pkg::health_t health;
    logic [47:0]       scale;
    logic              decreased;
    logic              increased;
  } step_report_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [47:0] cfg_wdata = '0;
  logic        grad_valid = 1'b0;
  logic        grad_ready;
  logic [31:0] grad_bits = '0;
  logic        last_element = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  health_code;
  logic [47:0] scale_now;
  logic        scale_decreased;
  logic        scale_increased;

  // Shadow registers and step state
  logic              sh_dyn_enable;
  logic [47:0]       sh_min_limit, sh_max_limit;
  logic [15:0]       sh_backoff;
  logic [23:0]       sh_growth;
  logic [15:0]       sh_interval;
  logic [47:0]       sh_loss_scale;
  logic [15:0]       sh_clean_steps;
  dlsc_pkg::health_t sh_verdict;
  logic              sh_seen_nonzero;

  step_report_t pending_reports[$];
  int mismatch_count = 0;
  int reports_checked = 0;
  int words_sent = 0;
  bit steady_flow = 1'b0;
  int rx_stall = 0;

  dynamic_loss_scale_controller u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .grad_valid      (grad_valid),
    .grad_ready      (grad_ready),
    .grad_bits       (grad_bits),
    .last_element    (last_element),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .health_code     (health_code),
    .scale_now       (scale_now),
    .scale_decreased (scale_decreased),
    .scale_increased (scale_increased)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run if the block stops making progress
  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int draw_idle();
    return steady_flow ? 0 : $urandom_range(0, 6);
  endfunction

  // floor(scale * factor / 2^16), saturated to the scale width
  function automatic logic [47:0] scaled_by_factor(logic [47:0] scale, logic [23:0] factor);
    logic [71:0] product;
    product = {24'b0, scale} * {48'b0, factor};
    product = product >> dlsc_pkg::FRACTION_BITS_DEF;
    if (|product[71:48])
      return '1;
    return product[47:0];
  endfunction

  function automatic void reset_shadow();
    sh_dyn_enable   = 1'b0;
    sh_min_limit    = dlsc_pkg::MIN_SCALE_RESET[47:0];
    sh_max_limit    = dlsc_pkg::MAX_SCALE_RESET[47:0];
    sh_backoff      = dlsc_pkg::BACKOFF_RESET;
    sh_growth       = dlsc_pkg::GROWTH_RESET;
    sh_interval     = dlsc_pkg::INTERVAL_RESET;
    sh_loss_scale   = dlsc_pkg::INIT_SCALE_RESET[47:0];
    sh_clean_steps  = '0;
    sh_verdict      = dlsc_pkg::HEALTH_OK;
    sh_seen_nonzero = 1'b0;
  endfunction

  function automatic void load_register(logic [2:0] idx, logic [47:0] data);
    case (idx)
      dlsc_pkg::REG_DYNAMIC_ENABLE:  sh_dyn_enable = data[0];
      dlsc_pkg::REG_INITIAL_SCALE:   sh_loss_scale = data;
      dlsc_pkg::REG_MIN_SCALE:       sh_min_limit = data;
      dlsc_pkg::REG_MAX_SCALE:       sh_max_limit = data;
      dlsc_pkg::REG_BACKOFF_FACTOR:  sh_backoff = data[15:0];
      dlsc_pkg::REG_GROWTH_FACTOR:   sh_growth = data[23:0];
      dlsc_pkg::REG_GROWTH_INTERVAL: sh_interval = data[15:0];
      default: ;
    endcase
  endfunction

  // Fold one accepted word into the step; on the last word queue the report
  function automatic void absorb_gradient(logic [31:0] word, logic last);
    step_report_t rep;
    if (sh_verdict == dlsc_pkg::HEALTH_OK && word[30:23] == dlsc_pkg::FLOAT_EXP_MAX)
      sh_verdict = (word[22:0] != 0) ? dlsc_pkg::HEALTH_NAN : dlsc_pkg::HEALTH_INF;
    if (word[30:0] != 0)
      sh_seen_nonzero = 1'b1;
    if (!last)
      return;

    if (sh_verdict != dlsc_pkg::HEALTH_OK)
      rep.health = sh_verdict;
    else if (!sh_seen_nonzero)
      rep.health = dlsc_pkg::HEALTH_ZERO;
    else
      rep.health = dlsc_pkg::HEALTH_OK;
    rep.decreased = 1'b0;
    rep.increased = 1'b0;

    // Back off on overflow, otherwise count clean steps toward growth
    if (sh_dyn_enable) begin
      if (rep.health == dlsc_pkg::HEALTH_NAN || rep.health == dlsc_pkg::HEALTH_INF) begin
        sh_loss_scale = scaled_by_factor(sh_loss_scale, {8'b0, sh_backoff});
        if (sh_loss_scale < sh_min_limit)
          sh_loss_scale = sh_min_limit;
        sh_clean_steps = '0;
        rep.decreased = 1'b1;
      end else begin
        sh_clean_steps = sh_clean_steps + 16'd1;
        if (sh_clean_steps >= sh_interval) begin
          sh_loss_scale = scaled_by_factor(sh_loss_scale, sh_growth);
          if (sh_loss_scale > sh_max_limit)
            sh_loss_scale = sh_max_limit;
          sh_clean_steps = '0;
          rep.increased = 1'b1;
        end
      end
    end

    sh_verdict = dlsc_pkg::HEALTH_OK;
    sh_seen_nonzero = 1'b0;
    rep.scale = sh_loss_scale;
    pending_reports.push_back(rep);
  endfunction

  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH @%0t: %s", $time, msg);
  endfunction

  // Check each accepted result against the oldest prediction, then draw the next stall
  always @(posedge clk) begin
    step_report_t exp_rep;
    if (rst) begin
      result_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_reports.size() == 0) begin
          note_failure($sformatf("unexpected result health %0d scale %h",
                                 health_code, scale_now));
        end else begin
          exp_rep = pending_reports.pop_front();
          if (health_code !== exp_rep.health || scale_now !== exp_rep.scale ||
              scale_decreased !== exp_rep.decreased ||
              scale_increased !== exp_rep.increased)
            note_failure($sformatf(
              {"report %0d: health exp %0d got %0d, scale exp %h got %h, ",
               "dec exp %0b got %0b, inc exp %0b got %0b"},
              reports_checked, exp_rep.health, health_code, exp_rep.scale, scale_now,
              exp_rep.decreased, scale_decreased, exp_rep.increased, scale_increased));
        end
        reports_checked++;
        rx_stall = draw_idle();
      end
      if (rx_stall > 0) begin
        rx_stall--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Send one gradient request after a random gap and wait for its acceptance
  task automatic send_word(input logic [31:0] word, input logic last);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      grad_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    grad_valid   <= 1'b1;
    grad_bits    <= word;
    last_element <= last;
    @(posedge clk);
    while (!grad_ready) @(posedge clk);
    absorb_gradient(word, last);
    words_sent++;
  endtask

  // Drop valid, wait for every predicted report, then let the pipeline settle
  task automatic wait_until_drained();
    grad_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold the write enable across back-to-back writes
  task automatic write_register(input logic [2:0] idx, input logic [47:0] data);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    load_register(idx, data);
  endtask

  task automatic apply_settings(input scale_settings_t s);
    write_register(dlsc_pkg::REG_MIN_SCALE, s.min_limit);
    write_register(dlsc_pkg::REG_MAX_SCALE, s.max_limit);
    write_register(dlsc_pkg::REG_BACKOFF_FACTOR, {32'b0, s.backoff});
    write_register(dlsc_pkg::REG_GROWTH_FACTOR, {24'b0, s.growth});
    write_register(dlsc_pkg::REG_GROWTH_INTERVAL, {32'b0, s.interval});
    write_register(dlsc_pkg::REG_INITIAL_SCALE, s.init_scale);
    write_register(dlsc_pkg::REG_DYNAMIC_ENABLE, {47'b0, s.dyn_enable});
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [47:0] rand_scale();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic [31:0] finite_word();
    logic [31:0] w;
    int pick;
    w = $urandom;
    pick = $urandom_range(0, 19);
    if (pick < 3)
      w[30:0] = '0;                          // signed zero
    else if (pick < 6)
      w[30:23] = 8'h00;                      // subnormal or zero
    else
      w[30:23] = 8'($urandom_range(1, 254)); // normal
    return w;
  endfunction

  function automatic logic [31:0] nonfinite_word();
    logic [31:0] w;
    w = $urandom;
    w[30:23] = dlsc_pkg::FLOAT_EXP_MAX;
    if ($urandom_range(0, 1))
      w[22:0] = '0;
    else if (w[22:0] == 0)
      w[22:0] = 23'd1;
    return w;
  endfunction

  // One step of random length and flavor, closed by a last word
  task automatic send_random_step();
    int len;
    int flavor;
    logic [31:0] w;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    flavor = $urandom_range(0, 9);
    for (int i = 0; i < len; i++) begin
      case (flavor)
        5: w = {$urandom_range(0, 1) == 1, 31'b0};
        6, 7, 8: w = ($urandom_range(0, 3) == 0) ? nonfinite_word() : finite_word();
        9: w = $urandom;
        default: w = finite_word();
      endcase
      send_word(w, i == len - 1);
    end
  endtask

  function automatic scale_settings_t phase_settings(int phase);
    scale_settings_t s;
    s.dyn_enable = 1'b1;
    s.init_scale = rand_scale();
    s.min_limit  = rand_scale() >> $urandom_range(8, 47);
    s.max_limit  = rand_scale() | 48'hFFFF_0000_0000;
    s.backoff    = 16'($urandom);
    s.growth     = 24'($urandom);
    s.interval   = 16'($urandom_range(0, 4));
    case (phase)
      0: begin
        s.init_scale = dlsc_pkg::INIT_SCALE_RESET[47:0];
        s.min_limit  = dlsc_pkg::MIN_SCALE_RESET[47:0];
        s.max_limit  = dlsc_pkg::MAX_SCALE_RESET[47:0];
        s.backoff    = dlsc_pkg::BACKOFF_RESET;
        s.growth     = dlsc_pkg::GROWTH_RESET;
        s.interval   = 16'd2;
      end
      // Largest scale and factors: saturate on growth, back off by almost nothing
      1: begin
        s.init_scale = '1;
        s.min_limit  = 48'd1;
        s.max_limit  = '1;
        s.backoff    = 16'hFFFF;
        s.growth     = 24'hFF_FFFF;
        s.interval   = 16'd0;
      end
      // Zero factors and zero floor drive the scale to zero
      2: begin
        s.init_scale = 48'd1;
        s.min_limit  = '0;
        s.max_limit  = 48'hFFFF;
        s.backoff    = '0;
        s.growth     = '0;
        s.interval   = 16'd1;
      end
      // Floor above ceiling, smallest factors
      3: begin
        s.min_limit = 48'h8000_0000_0000;
        s.max_limit = 48'h1_0000;
        s.backoff   = 16'd1;
        s.growth    = 24'h01_0001;
      end
      4: s.dyn_enable = 1'b0;
      5: begin
        s.init_scale = '0;
        s.min_limit  = '0;
        s.growth     = 24'h01_0000;
        s.interval   = 16'hFFFF;
      end
      default: ;
    endcase
    return s;
  endfunction

  // Registers at their reset values: scaling off, scale must hold
  task automatic test_register_defaults();
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h7FC0_0000, 1'b0);
    send_word(32'h3F80_0000, 1'b1);
    send_word(32'h3F80_0000, 1'b1);
    wait_until_drained();
  endtask

  // Every word class: signed zeros, subnormals, NaN and infinity first-wins
  task automatic test_word_classes();
    scale_settings_t s;
    s = '{1'b1, dlsc_pkg::INIT_SCALE_RESET[47:0], dlsc_pkg::MIN_SCALE_RESET[47:0],
          48'h100_0000_0000, dlsc_pkg::BACKOFF_RESET, dlsc_pkg::GROWTH_RESET, 16'd2};
    apply_settings(s);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h0000_0001, 1'b1);
    send_word(32'h7F7F_FFFF, 1'b0);
    send_word(32'h7FC0_0000, 1'b0);
    send_word(32'h7F80_0000, 1'b1);
    send_word(32'hFF80_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h7F80_0001, 1'b1);
    send_word(32'h807F_FFFF, 1'b1);
    send_word(32'hFF7F_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h3F80_0000, 1'b1);
    wait_until_drained();
  endtask

  // A write to an unmapped index must leave every register alone
  task automatic test_unmapped_index();
    write_register(UNMAPPED_REG_INDEX, '1);
    cfg_wr_en <= 1'b0;
    send_word(32'h4000_0000, 1'b1);
    send_word(32'h7F80_0000, 1'b1);
    wait_until_drained();
  endtask

  // Random steps under a series of register settings, some phases without idling
  task automatic test_random_settings();
    int target;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_settings(phase_settings(p));
      steady_flow = (p % 3 == 2);
      target = words_sent + WORDS_PER_PHASE;
      while (words_sent < target) send_random_step();
      wait_until_drained();
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    reset_shadow();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_register_defaults();
    test_word_classes();
    test_unmapped_index();
    test_random_settings();

    wait_until_drained();
    if (mismatch_count == 0 && pending_reports.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
